FILE: hw/rtl/hcbp_pkg.sv
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int STORE_BITS   = 32;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < STORE_BITS) ? MAX_CODE_LEN : STORE_BITS;

  localparam int TABLE_DEPTH  = 256;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  // Item that has been through the table lookup and waits for the packer.
  typedef struct packed {
    logic        valid;
    logic        flush;
    logic [31:0] code;
    logic [5:0]  len;
  } pack_req_t;

  // Group of packed bytes handed to the output buffer, first byte on top.
  typedef struct packed {
    logic        load;
    logic [31:0] word;
    logic [2:0]  count;
    logic        stream_end;
    logic [3:0]  pad;
  } burst_t;

endpackage

FILE: hw/rtl/hcbp_if.sv
`timescale 1ns / 1ps

interface hcbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  symbol;
  logic [31:0] code_value;
  logic [5:0]  code_length;

  modport source (output valid, output mode, output symbol, output code_value,
                  output code_length, input ready);
  modport sink (input valid, input mode, input symbol, input code_value,
                input code_length, output ready);
endinterface

interface hcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_end;
  logic [3:0] pad_count;

  modport source (output valid, output out_byte, output last_of_run,
                  output stream_end, output pad_count, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input stream_end, input pad_count, output ready);
endinterface

FILE: hw/rtl/hcbp_table.sv
`timescale 1ns / 1ps

module hcbp_table
  import hcbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  hcbp_in_if.sink   item,
  input  logic      take,
  output pack_req_t req
);

  logic [31:0] code_mem [TABLE_DEPTH];
  logic [5:0]  len_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;

  logic        accept;
  logic        is_load;
  logic        is_work;
  logic [5:0]  load_len;
  logic        stage_valid;
  logic        stage_flush;
  logic [31:0] code_rd;
  logic [5:0]  len_rd;
  logic        valid_rd;

  assign item.ready = !stage_valid || take;
  assign accept     = item.valid && item.ready;
  assign is_load    = (item.mode == MODE_LOAD);
  assign is_work    = (item.mode == MODE_ENCODE) || (item.mode == MODE_FLUSH);
  assign load_len   = (item.code_length > 6'(LEN_LIMIT)) ? 6'(LEN_LIMIT) : item.code_length;

  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      code_mem[item.symbol] <= item.code_value;
      len_mem[item.symbol]  <= load_len;
    end
  end

  // Registered table read, taken together with the item.
  always_ff @(posedge clk) begin
    if (accept) begin
      code_rd     <= code_mem[item.symbol];
      len_rd      <= len_mem[item.symbol];
      valid_rd    <= entry_valid[item.symbol];
      stage_flush <= (item.mode == MODE_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (accept && is_load) begin
        entry_valid[item.symbol] <= 1'b1;
      end
      if (accept) begin
        stage_valid <= is_work;
      end else if (take) begin
        stage_valid <= 1'b0;
      end
    end
  end

  // An entry never loaded reads as unused.
  always_comb begin
    req.valid = stage_valid;
    req.flush = stage_flush;
    req.code  = code_rd;
    req.len   = valid_rd ? len_rd : 6'd0;
  end

endmodule

FILE: hw/rtl/hcbp_pack.sv
`timescale 1ns / 1ps

module hcbp_pack
  import hcbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  pack_req_t req,
  input  logic      buf_free,
  output logic      take,
  output burst_t    burst
);

  logic [6:0]  pbits;
  logic [2:0]  pcount;
  logic [6:0]  pbits_next;
  logic [2:0]  pcount_next;

  logic [5:0]  total;
  logic [31:0] mask;
  logic [38:0] acc;
  logic [39:0] aligned;
  logic [2:0]  nbytes;
  logic [3:0]  pad;
  logic [7:0]  fbyte;
  logic        emits;

  always_comb begin
    total   = 6'({3'b0, pcount}) + req.len;
    mask    = ~(32'hFFFF_FFFF << req.len);
    acc     = (39'({pbits}) << req.len) | {7'b0, req.code & mask};
    // Left-align the accumulated bits so the earliest complete byte is on top.
    aligned = {1'b0, acc} << (6'd40 - total);
    nbytes  = total[5:3];
    pad     = 4'd8 - {1'b0, pcount};
    fbyte   = {1'b0, pbits} << pad;
    emits   = req.flush || (nbytes != 3'd0);
    take    = req.valid && (!emits || buf_free);

    burst.load       = take && emits;
    burst.word       = req.flush ? {fbyte, 24'b0} : aligned[39:8];
    burst.count      = req.flush ? 3'd1 : nbytes;
    burst.stream_end = req.flush;
    burst.pad        = req.flush ? pad : 4'd0;

    if (req.flush) begin
      pbits_next  = 7'd0;
      pcount_next = 3'd0;
    end else begin
      pbits_next  = acc[6:0] & ~(7'h7F << total[2:0]);
      pcount_next = total[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbits  <= 7'd0;
      pcount <= 3'd0;
    end else if (take) begin
      pbits  <= pbits_next;
      pcount <= pcount_next;
    end
  end

endmodule

FILE: hw/rtl/hcbp_outbuf.sv
`timescale 1ns / 1ps

module hcbp_outbuf
  import hcbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  burst_t      burst,
  output logic        buf_free,
  hcbp_out_if.source  result
);

  logic [31:0] word;
  logic [2:0]  count;
  logic        stream_end;
  logic [3:0]  pad;
  logic        pop;
  logic        last;

  assign last     = (count == 3'd1);
  assign pop      = result.valid && result.ready;
  assign buf_free = (count == 3'd0) || (last && result.ready);

  assign result.valid       = (count != 3'd0);
  assign result.out_byte    = word[31:24];
  assign result.last_of_run = last;
  assign result.stream_end  = stream_end && last;
  assign result.pad_count   = last ? pad : 4'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (burst.load) begin
      count <= burst.count;
    end else if (pop) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load) begin
      word       <= burst.word;
      stream_end <= burst.stream_end;
      pad        <= burst.pad;
    end else if (pop) begin
      word <= {word[23:0], 8'b0};
    end
  end

endmodule

FILE: hw/rtl/huffman_code_bit_packer.sv
`timescale 1ns / 1ps

// Huffman code bit packer. Load words write a 256-entry code table (code and
// length, lengths above 32 saturate); encode words append the symbol's code
// to a bit accumulator and emit every completed byte, earliest bit in the MSB;
// a flush word pads to a byte boundary and emits the final byte with its pad
// count (8 when already aligned). An input word is taken every cycle as long
// as the output keeps up: a word enters a registered table read, then the
// packer, whose bytes go to a four-byte output buffer that drains one byte
// per cycle while the result channel is ready. An encode word completing n
// bytes (at most 4) holds the result channel until all n are taken, so the
// sustained word rate is set by the output buffer drain. A word's first byte
// is offered once it has passed the registered table read and the packer has
// loaded it into the output buffer. The table needs no clearing after reset.
module huffman_code_bit_packer
  import hcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hcbp_in_if.sink    item,
  hcbp_out_if.source result
);

  pack_req_t req;
  burst_t    burst;
  logic      take;
  logic      buf_free;

  hcbp_table u_table (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .take (take),
    .req  (req)
  );

  hcbp_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .buf_free (buf_free),
    .take     (take),
    .burst    (burst)
  );

  hcbp_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .burst    (burst),
    .buf_free (buf_free),
    .result   (result)
  );

endmodule
